// ----- hw/rtl/coefficient_inverse_quantizer_core_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the coefficient inverse quantizer
// Shared concurrent assertion forms, clocked and disabled by the caller.
// ---------------------------------------------------------------------------
`ifndef COEFFICIENT_INVERSE_QUANTIZER_CORE_MACROS_SVH
`define COEFFICIENT_INVERSE_QUANTIZER_CORE_MACROS_SVH

// Same-cycle implication
`define CIQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define CIQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/ciq_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ciq_pkg
// Types, constants and register codes for the coefficient inverse quantizer.
// ---------------------------------------------------------------------------
package ciq_pkg;

   // Group geometry
   localparam int LANES       = 4;
   localparam int COEF_W      = 16;
   localparam int MAG_W       = COEF_W - 1;
   localparam int LEVEL_W     = 4;
   localparam int LANE_CNT_W  = 3;

   // Uniform reconstruction: shift is at least 2, so at most this many terms
   localparam int MAX_TERMS   = (MAG_W + 1) / 2;
   localparam int SHIFT_W     = LEVEL_W + 1;
   localparam int TERM_SH_W   = 7;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRUNC_LEVEL = 2'd0,
      CSR_QUANT_MODE  = 2'd1
   } csr_index_type;

   typedef enum logic {
      MODE_DEADZONE = 1'b0,
      MODE_UNIFORM  = 1'b1
   } quant_mode_type;

   typedef logic [COEF_W-1:0]              coef_type;
   typedef logic [LANES-1:0][COEF_W-1:0]   group_type;

   // Per-group control shared by all lanes
   typedef struct packed {
      logic                 active;
      quant_mode_type       mode;
      logic [LEVEL_W-1:0]   gtli;
      logic [SHIFT_W-1:0]   shift;
   } lane_ctrl_type;

endpackage

// ----- hw/rtl/coefficient_inverse_quantizer_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// coefficient_inverse_quantizer_core
// Inverse quantizer for one four-coefficient code group, lanes side by side.
// ---------------------------------------------------------------------------
//  channel  ports                         direction  transaction
//  req      req_valid / req_ready         in         one code group + gcli + lane count
//  rsp      rsp_valid / rsp_ready         out        one dequantized group
//  csr      csr_valid / csr_ready         in         one register write (index, data)
//
//  One group per cycle unless a held result is not being taken; the output register
//  follows the lane logic (eight-term shift-add per lane).
//  req_ready is low only while a held result is not being taken.
//  Reset clears the config registers (gtli 0, deadzone) and the output valid, not the output data.
//  csr writes are always taken; write only while the block is idle.
// ---------------------------------------------------------------------------
module coefficient_inverse_quantizer_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ciq_pkg::COEF_W-1:0]           req_coef_0,
   input  logic [ciq_pkg::COEF_W-1:0]           req_coef_1,
   input  logic [ciq_pkg::COEF_W-1:0]           req_coef_2,
   input  logic [ciq_pkg::COEF_W-1:0]           req_coef_3,
   input  logic [ciq_pkg::LEVEL_W-1:0]          req_group_level,
   input  logic [ciq_pkg::LANE_CNT_W-1:0]       req_lane_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ciq_pkg::COEF_W-1:0]           rsp_out_0,
   output logic [ciq_pkg::COEF_W-1:0]           rsp_out_1,
   output logic [ciq_pkg::COEF_W-1:0]           rsp_out_2,
   output logic [ciq_pkg::COEF_W-1:0]           rsp_out_3,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ciq_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ciq_pkg::CSR_DATA_W-1:0]       csr_data
);
   import ciq_pkg::*;

   logic [LEVEL_W-1:0] trunc_level_ff, trunc_level_in;
   quant_mode_type     quant_mode_ff, quant_mode_in;
   lane_ctrl_type      ctrl;
   group_type          coef_group;
   group_type          lane_result;
   group_type          out_group;
   logic [LANES-1:0]   lane_en;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      trunc_level_in = trunc_level_ff;
      quant_mode_in  = quant_mode_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TRUNC_LEVEL: trunc_level_in = csr_data[LEVEL_W-1:0];
            CSR_QUANT_MODE:  quant_mode_in  = quant_mode_type'(csr_data[0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trunc_level_ff <= '0;
         quant_mode_ff  <= MODE_DEADZONE;
      end else begin
         trunc_level_ff <= trunc_level_in;
         quant_mode_ff  <= quant_mode_in;
      end
   end

   // Group control: active when gtli is nonzero and gcli exceeds it
   always_comb begin
      ctrl.active = (trunc_level_ff != '0) && (req_group_level > trunc_level_ff);
      ctrl.mode   = quant_mode_ff;
      ctrl.gtli   = trunc_level_ff;
      ctrl.shift  = {1'b0, req_group_level} - {1'b0, trunc_level_ff} + SHIFT_W'(1);
   end

   assign coef_group[0] = req_coef_0;
   assign coef_group[1] = req_coef_1;
   assign coef_group[2] = req_coef_2;
   assign coef_group[3] = req_coef_3;

   // Lanes
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign lane_en[i] = LANE_CNT_W'(i) < req_lane_count;

      ciq_lane u_lane (
         .coef    (coef_group[i]),
         .lane_en (lane_en[i]),
         .ctrl    (ctrl),
         .result  (lane_result[i])
      );
   end

   // Merge and output register
   ciq_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .lane_result (lane_result),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_group   (out_group)
   );

   assign rsp_out_0 = out_group[0];
   assign rsp_out_1 = out_group[1];
   assign rsp_out_2 = out_group[2];
   assign rsp_out_3 = out_group[3];

endmodule

// ----- hw/rtl/ciq_lane.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ciq_lane
// Dequantizes one sign-magnitude coefficient (deadzone or uniform rule).
// ---------------------------------------------------------------------------
module ciq_lane (
   input  ciq_pkg::coef_type       coef,
   input  logic                    lane_en,
   input  ciq_pkg::lane_ctrl_type  ctrl,
   output ciq_pkg::coef_type       result
);
   import ciq_pkg::*;

   logic [MAG_W-1:0]     mag;
   logic [COEF_W-1:0]    acc;
   logic [TERM_SH_W-1:0] term_sh;
   coef_type             uniform_word;
   coef_type             deadzone_word;

   assign mag = coef[MAG_W-1:0];

   // Uniform: m + (m>>s) + (m>>2s) + ..., wrapping at 16 bits
   always_comb begin
      acc     = '0;
      term_sh = '0;
      for (int k = 0; k < MAX_TERMS; k++) begin
         term_sh = TERM_SH_W'(k) * TERM_SH_W'(ctrl.shift);
         acc     = acc + {1'b0, mag >> term_sh};
      end
      uniform_word = acc | {coef[COEF_W-1], {MAG_W{1'b0}}};
   end

   // Deadzone: set bit gtli-1 (gtli is nonzero when active)
   assign deadzone_word = coef | (COEF_W'(1) << (ctrl.gtli - LEVEL_W'(1)));

   // Zero magnitudes and inactive lanes pass through
   always_comb begin
      result = coef;
      if (ctrl.active && lane_en && (mag != '0)) begin
         result = (ctrl.mode == MODE_UNIFORM) ? uniform_word : deadzone_word;
      end
   end

endmodule

// ----- hw/rtl/ciq_merge.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ciq_merge
// Collects the lane results into one group and holds it in the output register.
// ---------------------------------------------------------------------------
`include "coefficient_inverse_quantizer_core_macros.svh"

module ciq_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  ciq_pkg::group_type  lane_result,
   output logic                out_valid,
   input  logic                out_ready,
   output ciq_pkg::group_type  out_group
);
   import ciq_pkg::*;

   logic      valid_ff, valid_in;
   group_type group_ff, group_in;
   logic      in_fire, out_fire;

   // Load when the output slot is empty or being drained this cycle
   assign in_ready = !valid_ff || out_ready;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = valid_ff && out_ready;

   always_comb begin
      valid_in = valid_ff;
      group_in = group_ff;
      if (in_fire) begin
         valid_in = 1'b1;
         group_in = lane_result;
      end else if (out_fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      group_ff <= group_in;
   end

   assign out_valid = valid_ff;
   assign out_group = group_ff;

   // Checks
   `CIQ_ASSERT_NEXT(a_load_sets_valid, clock, reset, in_fire, valid_ff, "accepted group lost")
   `CIQ_ASSERT_NEXT(a_drain_clears, clock, reset, out_fire && !in_fire, !valid_ff, "group repeated")
   `CIQ_ASSERT_IMPL(a_empty_ready, clock, reset, !valid_ff, in_ready, "empty stage not ready")
   `CIQ_ASSERT_NEXT(a_load_data, clock, reset, in_fire, group_ff == $past(lane_result), "bad load")

endmodule
